// ----- rtl/core/sparse_matrix_one_norm_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sparse matrix 1-norm block
// Concurrent check wrappers; define NO_ASSERTIONS to drop all checks.
// ----------------------------------------------------------------------------
`ifndef SPARSE_MATRIX_ONE_NORM_MACROS_SVH
`define SPARSE_MATRIX_ONE_NORM_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define SMON_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define SMON_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define SMON_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define SMON_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/smon_pkg.sv -----
// ----------------------------------------------------------------------------
// smon_pkg
// Shared types and constants of the sparse matrix 1-norm block.
// ----------------------------------------------------------------------------
package smon_pkg;

   localparam int MAX_COLUMNS_DEF = 1024;
   localparam int COL_W           = 10;
   localparam int VALUE_W         = 32;
   localparam int SUM_W           = 48;
   localparam int QUEUE_DEPTH     = 4;

   typedef struct packed {
      logic signed [VALUE_W-1:0] entry_value;
      logic [COL_W-1:0]          entry_column;
      logic                      last_entry;
   } req_type;

   typedef struct packed {
      logic [SUM_W-1:0] norm_value;
      logic             saturated;
   } rsp_type;

   // classified entry handed from front to back
   typedef struct packed {
      logic [VALUE_W-1:0] mag;
      logic [COL_W-1:0]   column;
      logic               in_range;
      logic               last;
   } work_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_RUN,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } back_state_type;

endpackage

// ----- rtl/core/smon_ram.sv -----
// ----------------------------------------------------------------------------
// smon_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module smon_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/smon_front.sv -----
// ----------------------------------------------------------------------------
// smon_front
// Accepts entries, takes the magnitude, range-checks the column and queues.
// ----------------------------------------------------------------------------
module smon_front #(
   parameter int MAX_COLUMNS = smon_pkg::MAX_COLUMNS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  smon_pkg::req_type  req_data,
   output logic               q_valid,
   input  logic               q_ready,
   output smon_pkg::work_type q_item
);

   import smon_pkg::*;

   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   work_type            q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                push, pop;
   logic [VALUE_W-1:0]  raw;
   work_type            classified;

   // classify: two's complement magnitude (most negative maps to 2^31)
   always_comb begin
      raw                 = VALUE_W'(req_data.entry_value);
      classified.mag      = raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
      classified.column   = req_data.entry_column;
      classified.in_range = ({{(32-COL_W){1'b0}}, req_data.entry_column} < 32'(MAX_COLUMNS));
      classified.last     = req_data.last_entry;
   end

   assign req_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_valid && q_ready;
   assign q_item    = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QPTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// ----- rtl/core/smon_back.sv -----
// ----------------------------------------------------------------------------
// smon_back
// Column sum accumulation with forwarding, norm scan and store clearing.
// ----------------------------------------------------------------------------
`include "sparse_matrix_one_norm_macros.svh"

module smon_back #(
   parameter int MAX_COLUMNS = smon_pkg::MAX_COLUMNS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_ready,
   input  smon_pkg::work_type q_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output smon_pkg::rsp_type  rsp_data
);

   import smon_pkg::*;

   localparam int COL_SPAN = 1 << COL_W;
   localparam int DEPTH    = (MAX_COLUMNS < COL_SPAN) ? MAX_COLUMNS : COL_SPAN;
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   back_state_type    state_ff, state_in;
   logic              s1_valid_ff;
   work_type          s1_ff;
   logic              fwd_valid_ff;
   logic [ADDR_W-1:0] fwd_addr_ff;
   logic [SUM_W-1:0]  fwd_sum_ff;
   logic [ADDR_W-1:0] high_ff, high_in;
   logic              sat_ff, sat_in;
   logic [SUM_W-1:0]  best_ff, best_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic              rdv_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   logic              pop;
   logic              rsp_load;
   logic              wr_en, rd_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [SUM_W-1:0]  wr_data, rd_data;
   logic [ADDR_W-1:0] s1_addr;
   logic              s1_write;
   logic [SUM_W-1:0]  old_sum, new_sum;
   logic [SUM_W:0]    add_sum;

   smon_ram #(
      .WIDTH (SUM_W),
      .DEPTH (DEPTH)
   ) u_sums (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // stage 1 accumulate; a write at the same edge as our read is forwarded
   assign s1_addr  = s1_ff.column[ADDR_W-1:0];
   assign s1_write = s1_valid_ff && s1_ff.in_range;

   always_comb begin
      old_sum = (fwd_valid_ff && (fwd_addr_ff == s1_addr)) ? fwd_sum_ff : rd_data;
      add_sum = {1'b0, old_sum} + {{(SUM_W+1-VALUE_W){1'b0}}, s1_ff.mag};
      new_sum = add_sum[SUM_W] ? {SUM_W{1'b1}} : add_sum[SUM_W-1:0];
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (addr_ff == ADDR_W'(DEPTH-1)) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (s1_valid_ff && s1_ff.last) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (addr_ff == high_ff) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_RUN;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      pop      = 1'b0;
      rsp_load = 1'b0;
      wr_en    = 1'b0;
      wr_addr  = addr_ff;
      wr_data  = '0;
      rd_en    = 1'b0;
      rd_addr  = addr_ff;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
         end
         ST_RUN: begin
            pop     = q_valid && !(s1_valid_ff && s1_ff.last);
            rd_en   = pop;
            rd_addr = q_item.column[ADDR_W-1:0];
            wr_en   = s1_write;
            wr_addr = s1_addr;
            wr_data = new_sum;
         end
         ST_SCAN: begin
            // read old sum and zero the column in the same cycle
            rd_en = 1'b1;
            wr_en = 1'b1;
         end
         ST_FINISH: begin
            rsp_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   assign q_ready = pop;

   always_comb begin
      addr_in = '0;
      if (state_ff == ST_CLEAR && addr_ff != ADDR_W'(DEPTH-1)) begin
         addr_in = addr_ff + ADDR_W'(1);
      end else if (state_ff == ST_SCAN && addr_ff != high_ff) begin
         addr_in = addr_ff + ADDR_W'(1);
      end

      high_in = high_ff;
      sat_in  = sat_ff;
      best_in = best_ff;
      if (rsp_load) begin
         high_in = '0;
         sat_in  = 1'b0;
         best_in = '0;
      end else begin
         if (s1_write && s1_addr > high_ff) high_in = s1_addr;
         if (s1_write && add_sum[SUM_W]) sat_in = 1'b1;
         if (rdv_ff && rd_data > best_ff) best_in = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         high_ff      <= '0;
         sat_ff       <= 1'b0;
         best_ff      <= '0;
         addr_ff      <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= pop;
         fwd_valid_ff <= s1_write;
         high_ff      <= high_in;
         sat_ff       <= sat_in;
         best_ff      <= best_in;
         addr_ff      <= addr_in;
         rdv_ff       <= (state_ff == ST_SCAN);
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         s1_ff <= q_item;
      end
      fwd_addr_ff <= s1_addr;
      fwd_sum_ff  <= new_sum;
      if (rsp_load) begin
         rsp_ff.norm_value <= best_ff;
         rsp_ff.saturated  <= sat_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SMON_ASSERT_IMPLIES(a_no_item_in_scan, clock, reset, state_ff == ST_SCAN, !s1_valid_ff)
   `SMON_ASSERT_IMPLIES(a_scan_in_bound, clock, reset, state_ff == ST_SCAN, addr_ff <= high_ff)
   `SMON_ASSERT_NEXT(a_clear_after_rsp, clock, reset, rsp_load, high_ff == '0 && !sat_ff && best_ff == '0)
   `SMON_ASSERT_IMPLIES(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_FINISH)

endmodule

// ----- rtl/core/sparse_matrix_one_norm.sv -----
// Result: a non-last entry gives no result; a last entry starts a scan of
//   columns 0 to highest_column (one read per column) before rsp_valid rises.
// Throughput: one entry per cycle while streaming; a last entry stalls the back
//   end for the scan plus any wait on rsp_ready (one RAM port).
// Reset: synchronous, active high; afterwards the column-sum RAM is zeroed, one
//   entry a cycle, over all min(MAX_COLUMNS, 1024) entries; up to 4 entries queue meanwhile.
// ----------------------------------------------------------------------------
// sparse_matrix_one_norm
// Matrix 1-norm (largest absolute column sum) over a stream of sparse entries.
// ----------------------------------------------------------------------------
module sparse_matrix_one_norm #(
   parameter int MAX_COLUMNS = smon_pkg::MAX_COLUMNS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   // entry channel
   input  logic              req_valid,
   output logic              req_ready,
   input  smon_pkg::req_type req_data,
   // norm result channel
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output smon_pkg::rsp_type rsp_data
);

   import smon_pkg::*;

   // front -> back queue head
   logic     q_valid;
   logic     q_ready;
   work_type q_item;

   // Front: takes each item, forms |value| (the most negative value maps
   // to 2^31 exactly), flags columns at or beyond MAX_COLUMNS, and holds
   // up to QUEUE_DEPTH classified entries so intake continues while the
   // back end scans or waits on the result channel.
   smon_front #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_item    (q_item)
   );

   // Back: read-modify-write of the column sum RAM, one entry per cycle while
   // streaming, with a one-deep bypass for back-to-back hits on the same column.
   // Sums saturate at 2^48-1 and set a sticky flag. A last entry starts a
   // scan of columns 0..highest that takes the maximum and zeroes each
   // column as it is read; the result sits in an output register so the
   // next matrix can start as soon as the result is loaded.
   smon_back #(
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_ready   (q_ready),
      .q_item    (q_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams sparse matrix entries into the 1-norm block and checks every norm
// item against a behavioral column accumulator. A directed set of extreme
// entries runs first, then a matrix with repeated full-scale hits on one
// column, then random matrices under several back-pressure mixes.
// ----------------------------------------------------------------------------
module testbench;
   import smon_pkg::*;

   localparam int COLUMN_COUNT     = MAX_COLUMNS_DEF;
   localparam int RESET_CYCLES     = 8;
   localparam int PCT_HEAVY        = 64;
   localparam int PCT_LIGHT        = 12;
   localparam int PHASE_ITEMS      = 80;
   localparam int HOLDOFF_CYCLES   = 600;
   localparam int PRESSURE_MATRICES = 40;
   // full-scale entries piled onto one column
   localparam int HEAVY_ENTRIES    = 8;
   // longest scan reads every column up to the highest one written
   localparam int DRAIN_CYCLES     = 1100;
   localparam int TIMEOUT_CYCLES   = 5_000_000;
   localparam int MISMATCH_SHOWN   = 10;

   localparam logic [SUM_W-1:0]   SUM_LIMIT     = '1;
   localparam logic [VALUE_W-1:0] MOST_NEGATIVE = 32'h8000_0000;
   localparam logic [VALUE_W-1:0] MOST_POSITIVE = 32'h7FFF_FFFF;
   localparam logic [VALUE_W-1:0] MINUS_ONE     = 32'hFFFF_FFFF;
   localparam logic [VALUE_W-1:0] ONE_POINT_ZERO = 32'h0001_0000;
   localparam logic [COL_W-1:0]   TOP_INDEX     = '1;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   sparse_matrix_one_norm #(
      .MAX_COLUMNS(COLUMN_COUNT)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // entries waiting to be offered, and norms still owed by the block
   req_type entry_queue[$];
   rsp_type norm_expected[$];

   // behavioral copy of the block's per-matrix state
   logic [SUM_W-1:0] column_totals [COLUMN_COUNT];
   int               top_column    = 0;
   logic             overflow_seen = 1'b0;

   logic entry_taken        = 1'b0;
   int   sender_idle_pct    = 0;
   int   receiver_stall_pct = 0;
   logic holdoff_go         = 1'b0;
   int   holdoff_left       = 0;
   int   mismatch_count     = 0;

   function automatic void clear_column_totals();
      foreach (column_totals[i]) column_totals[i] = '0;
      top_column    = 0;
      overflow_seen = 1'b0;
   endfunction

   // Add one entry's magnitude into its column; on the last entry of a
   // matrix, scan for the largest column and queue the norm.
   function automatic void accumulate_entry(req_type e);
      logic [VALUE_W-1:0] raw;
      logic [VALUE_W-1:0] mag;
      logic [SUM_W:0]     wide;
      logic [SUM_W-1:0]   best;
      rsp_type            norm;
      int                 col;
      int                 j;
      raw = e.entry_value;
      // negating the most negative value wraps back to 2^31, its true magnitude
      mag = raw[VALUE_W-1] ? -raw : raw;
      col = int'(e.entry_column);
      if (col < COLUMN_COUNT) begin
         wide = {1'b0, column_totals[col]} + (SUM_W+1)'(mag);
         if (wide[SUM_W]) begin
            column_totals[col] = SUM_LIMIT;
            overflow_seen      = 1'b1;
         end else begin
            column_totals[col] = wide[SUM_W-1:0];
         end
         if (col > top_column) top_column = col;
      end
      if (e.last_entry) begin
         best = '0;
         for (j = 0; j <= top_column; j++) begin
            if (column_totals[j] > best) best = column_totals[j];
         end
         norm.norm_value = best;
         norm.saturated  = overflow_seen;
         norm_expected = {norm_expected, norm};
         clear_column_totals();
      end
   endfunction

   function automatic void note_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= MISMATCH_SHOWN) $display("%0t: %s", $time, what);
   endfunction

   function automatic void queue_entry(logic [VALUE_W-1:0] value, logic [COL_W-1:0] col,
                                       logic last);
      req_type e;
      e.entry_value  = value;
      e.entry_column = col;
      e.last_entry   = last;
      entry_queue = {entry_queue, e};
   endfunction

   // extremes show up often, small values sometimes, the rest is full-range noise
   function automatic logic [VALUE_W-1:0] random_value();
      logic [VALUE_W-1:0] v;
      case ($urandom_range(0, 7))
         0: v = MOST_NEGATIVE;
         1: v = MOST_POSITIVE;
         2: v = MINUS_ONE;
         3: v = '0;
         4: begin
            v = $urandom_range(0, 65535);
            if ($urandom_range(0, 1)) v = -v;
         end
         default: v = $urandom();
      endcase
      return v;
   endfunction

   // One matrix of 1..16 entries. Most stay in the first 16 columns so the
   // scan is short; about one in six spreads over every column.
   function automatic int queue_random_matrix();
      int length;
      int k;
      logic spread;
      length = $urandom_range(1, 16);
      spread = ($urandom_range(0, 5) == 0);
      for (k = 0; k < length; k++) begin
         queue_entry(random_value(),
                     spread ? COL_W'($urandom_range(0, COLUMN_COUNT - 1))
                            : COL_W'($urandom_range(0, 15)),
                     k == length - 1);
      end
      return length;
   endfunction

   task automatic wait_entries_sent();
      while (entry_queue.size() != 0 || req_valid) @(posedge clock);
   endtask

   task automatic run_random_phase(int send_pct, int stall_pct, int item_goal);
      int queued;
      queued = 0;
      @(posedge clock);
      sender_idle_pct    = send_pct;
      receiver_stall_pct = stall_pct;
      while (queued < item_goal) queued += queue_random_matrix();
      wait_entries_sent();
   endtask

   // ---------------------------------------------------------------------
   // Entry driver: moves on at the falling edge once the current item was
   // taken at the previous rising edge; otherwise holds valid and payload.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || entry_taken) begin
         if (entry_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            req_valid <= 1'b1;
            req_data  <= entry_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Accepted entries feed the predictor right at the edge they cross.
   always @(posedge clock) begin
      if (reset) begin
         entry_taken <= 1'b0;
         clear_column_totals();
      end else begin
         entry_taken <= req_valid && req_ready;
         if (req_valid && req_ready) accumulate_entry(req_data);
      end
   end

   // ---------------------------------------------------------------------
   // Norm receiver: random stalls, forced low during a hold-off.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset || holdoff_left > 0) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // hold-off length counted here, independent of the stimulus
   always @(posedge clock) begin
      if (holdoff_go) begin
         holdoff_left <= HOLDOFF_CYCLES;
      end else if (holdoff_left > 0) begin
         holdoff_left <= holdoff_left - 1;
      end
   end

   // Norm monitor: each item against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (norm_expected.size() == 0) begin
            note_mismatch($sformatf("unexpected norm %h sat %b",
                                    rsp_data.norm_value, rsp_data.saturated));
         end else begin
            want = norm_expected.pop_front();
            if (rsp_data.norm_value !== want.norm_value ||
                rsp_data.saturated !== want.saturated) begin
               note_mismatch($sformatf("norm: expected %h sat %b, got %h sat %b",
                                       want.norm_value, want.saturated,
                                       rsp_data.norm_value, rsp_data.saturated));
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      int k;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed, no idling. The block is still clearing its RAM after
      // reset; the driver just waits on ready.
      @(posedge clock);
      // most positive and most negative in one column, smallest step in the top one
      queue_entry(MOST_POSITIVE, '0, 1'b0);
      queue_entry(MOST_NEGATIVE, '0, 1'b0);
      queue_entry(MINUS_ONE, TOP_INDEX, 1'b0);
      queue_entry('0, 10'd5, 1'b0);
      queue_entry(ONE_POINT_ZERO, 10'd3, 1'b1);
      // single zero entry: norm of zero
      queue_entry('0, '0, 1'b1);
      // lone negative last entry in the top column
      queue_entry(-ONE_POINT_ZERO, TOP_INDEX, 1'b1);
      // never-written columns below the highest one count as zero
      queue_entry(32'h0000_0003, 10'd7, 1'b0);
      queue_entry(-32'sd2, 10'd2, 1'b1);
      // repeated hits on one column, the winner not the highest column
      queue_entry(MOST_NEGATIVE, 10'd1, 1'b0);
      queue_entry(MOST_NEGATIVE, 10'd1, 1'b0);
      queue_entry(MOST_POSITIVE, 10'd1, 1'b0);
      queue_entry(32'h5555_5555, 10'd512, 1'b0);
      queue_entry(32'hAAAA_AAAA, 10'd682, 1'b0);
      queue_entry(32'h0000_0001, 10'd341, 1'b1);
      // last on a zero entry after a full-width one in another column
      queue_entry(32'h1234_5678, 10'd9, 1'b0);
      queue_entry('0, 10'd4, 1'b1);
      wait_entries_sent();

      // One column hit back to back at full scale, plus a far column;
      // the next matrix must start from a clean store.
      @(posedge clock);
      for (k = 0; k < HEAVY_ENTRIES; k++) queue_entry(MOST_NEGATIVE, 10'd2, 1'b0);
      queue_entry(32'h0000_0001, 10'd900, 1'b0);
      queue_entry(MOST_NEGATIVE, 10'd2, 1'b1);
      queue_entry(ONE_POINT_ZERO, 10'd2, 1'b1);
      wait_entries_sent();

      // random matrices under each idling mix
      run_random_phase(0, 0, PHASE_ITEMS);
      run_random_phase(PCT_HEAVY, 0, PHASE_ITEMS);
      run_random_phase(0, PCT_HEAVY, PHASE_ITEMS);
      run_random_phase(PCT_LIGHT, PCT_LIGHT, PHASE_ITEMS);

      // Long receiver hold-off with short matrices streaming in, so the
      // result buffer fills and intake backs up.
      @(negedge clock);
      holdoff_go <= 1'b1;
      @(negedge clock);
      holdoff_go <= 1'b0;
      @(posedge clock);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      for (k = 0; k < PRESSURE_MATRICES; k++) begin
         queue_entry(random_value(), COL_W'($urandom_range(0, 7)), 1'b0);
         queue_entry(random_value(), COL_W'($urandom_range(0, 7)), 1'b1);
      end
      wait_entries_sent();

      // drain, then give a stray result time to show up
      while (norm_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && norm_expected.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

   initial begin
      repeat (TIMEOUT_CYCLES) @(posedge clock);
      $display("testbench: done, errors");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/smon_pkg.sv
rtl/core/smon_ram.sv
rtl/core/smon_front.sv
rtl/core/smon_back.sv
rtl/core/sparse_matrix_one_norm.sv
test/testbench.sv
